// ----- rtl/sector_record_unpacker_unit_assert.svh -----
// Assertion macros used by the record unpacker top file.
`ifndef SECTOR_RECORD_UNPACKER_UNIT_ASSERT_SVH
`define SECTOR_RECORD_UNPACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record unpacker check failed");

// Next-cycle implication, checked outside reset.
`define SRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record unpacker check failed");

`endif

// ----- rtl/sru_pkg.sv -----
`timescale 1ns / 1ps
package sru_pkg;

   localparam int SECTOR_BYTES = 256;
   localparam int POS_W        = $clog2(SECTOR_BYTES);
   localparam int SPAN_W       = 10;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  END_OF_SECTOR = 8'hFF;
   localparam logic [7:0]  NEWLINE_CHAR  = 8'd10;
   localparam logic [7:0]  TERMINATOR    = 8'd0;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      PHASE_LENGTH = 3'b001,
      PHASE_RECORD = 3'b010,
      PHASE_SKIP   = 3'b100
   } phase_type;

   // One accepted byte's worth of results.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       has_char;
      logic       has_newline;
      logic       has_eot;
   } entry_type;

   typedef struct packed {
      logic       in_record;
      logic [7:0] record_left;
      logic [7:0] copy_left;
   } front_status_type;

endpackage

// ----- rtl/sru_front.sv -----
`timescale 1ns / 1ps
module sru_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [7:0]                data_byte,
   input  logic                      final_byte,
   input  logic [15:0]               capacity,
   output logic                      push,
   output sru_pkg::entry_type        push_entry,
   output sru_pkg::front_status_type status
);

   logic [sru_pkg::POS_W-1:0] pos_ff, pos_in;
   sru_pkg::phase_type        phase_ff, phase_in;
   logic [7:0]                rec_left_ff, rec_left_in;
   logic [7:0]                copy_left_ff, copy_left_in;
   logic [15:0]               emitted_ff, emitted_in;
   logic                      halted_ff, halted_in;

   logic [15:0]               limit;
   logic [15:0]               room;
   logic [sru_pkg::SPAN_W-1:0] span;
   logic [7:0]                rec_after;
   logic                      put_char;
   logic                      put_nl;

   assign limit = ((capacity == 16'd0) ? 16'd1 : capacity) - 16'd1;
   assign room  = limit - emitted_ff - 16'd1;
   assign span  = sru_pkg::SPAN_W'(pos_ff) + sru_pkg::SPAN_W'(data_byte)
                  + sru_pkg::SPAN_W'(1);
   assign rec_after = rec_left_ff - ((rec_left_ff != 8'd0) ? 8'd1 : 8'd0);

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      rec_left_in  = rec_left_ff;
      copy_left_in = copy_left_ff;
      halted_in    = halted_ff;
      put_char     = 1'b0;
      put_nl       = 1'b0;

      if (!halted_ff) begin
         unique case (phase_ff)
            sru_pkg::PHASE_LENGTH: begin
               if (emitted_ff >= limit) begin
                  halted_in = 1'b1;
               end else if (data_byte == sru_pkg::END_OF_SECTOR) begin
                  phase_in = sru_pkg::PHASE_SKIP;
               end else if (span > sru_pkg::SPAN_W'(sru_pkg::SECTOR_BYTES)) begin
                  phase_in = sru_pkg::PHASE_SKIP;
               end else begin
                  rec_left_in  = data_byte;
                  copy_left_in = ({8'd0, data_byte} < room) ? data_byte : room[7:0];
                  if (data_byte == 8'd0) begin
                     put_nl = 1'b1;
                  end else begin
                     phase_in = sru_pkg::PHASE_RECORD;
                  end
               end
            end
            sru_pkg::PHASE_RECORD: begin
               if (copy_left_ff != 8'd0) begin
                  put_char     = 1'b1;
                  copy_left_in = copy_left_ff - 8'd1;
               end
               rec_left_in = rec_after;
               if (rec_after == 8'd0) begin
                  put_nl = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      emitted_in = emitted_ff + 16'(put_char) + 16'(put_nl);
      if (put_nl) begin
         phase_in = sru_pkg::PHASE_LENGTH;
         if (emitted_in >= limit) begin
            halted_in = 1'b1;
         end
      end

      // wrap at the sector end; a skip ends with the sector
      if (pos_ff == sru_pkg::POS_W'(sru_pkg::SECTOR_BYTES - 1)) begin
         pos_in = '0;
         if (phase_in != sru_pkg::PHASE_RECORD) begin
            phase_in = sru_pkg::PHASE_LENGTH;
         end
      end else begin
         pos_in = pos_ff + sru_pkg::POS_W'(1);
      end

      if (final_byte) begin
         pos_in       = '0;
         phase_in     = sru_pkg::PHASE_LENGTH;
         rec_left_in  = 8'd0;
         copy_left_in = 8'd0;
         emitted_in   = 16'd0;
         halted_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= sru_pkg::PHASE_LENGTH;
         rec_left_ff  <= 8'd0;
         copy_left_ff <= 8'd0;
         emitted_ff   <= 16'd0;
         halted_ff    <= 1'b0;
      end else if (take) begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         rec_left_ff  <= rec_left_in;
         copy_left_ff <= copy_left_in;
         emitted_ff   <= emitted_in;
         halted_ff    <= halted_in;
      end
   end

   assign push                   = take && (put_char || put_nl || final_byte);
   assign push_entry.text_byte   = data_byte;
   assign push_entry.has_char    = put_char;
   assign push_entry.has_newline = put_nl;
   assign push_entry.has_eot     = final_byte;

   assign status.in_record   = (phase_ff == sru_pkg::PHASE_RECORD);
   assign status.record_left = rec_left_ff;
   assign status.copy_left   = copy_left_ff;

endmodule

// ----- rtl/sru_queue.sv -----
`timescale 1ns / 1ps
module sru_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sru_pkg::entry_type push_entry,
   input  logic               pop,
   output sru_pkg::entry_type head_entry,
   output logic               full,
   output logic               empty
);

   sru_pkg::entry_type          slot_ff [sru_pkg::QUEUE_DEPTH];
   logic [sru_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [sru_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == sru_pkg::QCNT_W'(sru_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + sru_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - sru_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + sru_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + sru_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/sru_back.sv -----
`timescale 1ns / 1ps
module sru_back (
   input  logic               clock,
   input  logic               reset,
   input  sru_pkg::entry_type head_entry,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_text_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_text
);

   logic char_done_ff;
   logic nl_done_ff;
   logic show_char;
   logic show_nl;
   logic fire;

   assign show_char = head_entry.has_char && !char_done_ff;
   assign show_nl   = head_entry.has_newline && !nl_done_ff && !show_char;
   assign rsp_valid = !empty;
   assign fire      = rsp_valid && rsp_ready;

   always_comb begin
      if (show_char) begin
         rsp_text_byte   = head_entry.text_byte;
         rsp_last_of_run = !(head_entry.has_newline || head_entry.has_eot);
         rsp_end_of_text = 1'b0;
      end else if (show_nl) begin
         rsp_text_byte   = sru_pkg::NEWLINE_CHAR;
         rsp_last_of_run = !head_entry.has_eot;
         rsp_end_of_text = 1'b0;
      end else begin
         rsp_text_byte   = sru_pkg::TERMINATOR;
         rsp_last_of_run = 1'b1;
         rsp_end_of_text = 1'b1;
      end
   end

   assign pop = fire && rsp_last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_done_ff <= 1'b0;
         nl_done_ff   <= 1'b0;
      end else if (fire) begin
         if (rsp_last_of_run) begin
            char_done_ff <= 1'b0;
            nl_done_ff   <= 1'b0;
         end else if (show_char) begin
            char_done_ff <= 1'b1;
         end else begin
            nl_done_ff <= 1'b1;
         end
      end
   end

endmodule

// ----- rtl/sector_record_unpacker_unit.sv -----
`timescale 1ns / 1ps
// Record unpacker: takes a file's data area one byte per cycle (req_), in whole
// sectors of sru_pkg::SECTOR_BYTES bytes, and delivers text one character per
// cycle (rsp_): each record's characters, then a newline; the byte flagged
// final adds a terminating zero and returns the parser to its start state.
// csr_data sets the text buffer capacity (reset 65535); at most capacity - 1
// characters come out, and the record that hits the limit is cut so its newline
// still fits. Write csr only while idle. Rate: the parser takes one byte every
// cycle as long as its 4-entry result queue has room; the output side drains one
// character per cycle while rsp_ready is high, and a byte yields up to 3 results
// (character, newline, terminator), each one output character; a byte with none
// gives no output. No clearing pass follows reset.
`include "sector_record_unpacker_unit_assert.svh"
module sector_record_unpacker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_text,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0]               capacity_ff;
   logic                      take;
   logic                      push;
   logic                      pop;
   logic                      full;
   logic                      empty;
   sru_pkg::entry_type        push_entry;
   sru_pkg::entry_type        head_entry;
   sru_pkg::front_status_type front_status;

   // capacity register: always ready; writes belong while the block is idle, which the block itself does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= sru_pkg::CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // accept a byte whenever the queue can hold its results
   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   sru_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .capacity   (capacity_ff),
      .push       (push),
      .push_entry (push_entry),
      .status     (front_status)
   );

   // decouple the parser from the output stall
   sru_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (full),
      .empty      (empty)
   );

   // serialize each queued entry into characters
   sru_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_text (rsp_end_of_text)
   );

   // the terminator always closes its run and is a zero
   `SRU_ASSERT_NOW(a_eot_closes_run, clock, reset, rsp_valid && rsp_end_of_text, rsp_last_of_run && (rsp_text_byte == sru_pkg::TERMINATOR))
   // back-pressure on input only comes from results waiting at the output
   `SRU_ASSERT_NOW(a_stall_has_output, clock, reset, !req_ready, rsp_valid)
   // a cut record never copies more than it has left
   `SRU_ASSERT_NOW(a_copy_within_record, clock, reset, front_status.in_record, front_status.copy_left <= front_status.record_left)

endmodule
